[design/sha256_pkg.sv]
// Package: SHA-256 types, constants and round functions.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       write_byte;   // store in_byte at fill position
        logic [7:0] in_byte;
        logic       count_byte;   // advance message byte count
        logic       load_len;     // write length field into bytes 56..63
        logic       start;        // load schedule and working vars
        logic       round;        // run one round
        logic       fold;         // add working vars into chain
        logic       reinit;       // start a new message
        logic       shift_out;    // rotate chain for digest output
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] rnd;
    } sha_stat_t;

    localparam logic [7:0] PadMark  = 8'h80;
    localparam logic [5:0] LenPos   = 6'd56;

    localparam logic [31:0] InitChain [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[design/sha256_datapath.sv]
// Datapath: block buffer, schedule window, working variables, chain and byte count.
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    output logic [31:0] chain_head
);
    // Block buffer kept as sixteen big-endian words; bytes land in their lane.
    logic [31:0] buf_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] bits;

    logic [31:0] wv, g0, g1, s1, ch, t1, s0, mj;

    assign bits = {count_reg, 3'b000};

    always_comb
    begin
        g0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wv = (rnd_reg < 6'd16) ? w_reg[0] : (w_reg[0] + g0 + w_reg[9] + g1);
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + RoundConst[rnd_reg] + wv;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_comb
    begin
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        count_next = count_reg;
        if (cmd.write_byte)
            fill_next = fill_reg + 6'd1;
        if (cmd.count_byte)
            count_next = count_reg + 61'd1;
        if (cmd.start)
            rnd_next = '0;
        if (cmd.round)
            rnd_next = rnd_reg + 6'd1;
        if (cmd.reinit)
        begin
            fill_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rnd_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            count_reg <= count_next;
        end
    end

    // Buffer writes; the window rolls so the current word is always at slot 0.
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= cmd.in_byte;
        if (cmd.load_len)
        begin
            buf_reg[14] <= bits[63:32];
            buf_reg[15] <= bits[31:0];
        end
        if (cmd.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= buf_reg[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wv;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + s0 + mj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < 8; i++)
                h_reg[i] <= InitChain[i];
        else if (cmd.reinit)
            for (int i = 0; i < 8; i++)
                h_reg[i] <= InitChain[i];
        else if (cmd.fold)
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        else if (cmd.shift_out)
        begin
            for (int i = 0; i < 7; i++)
                h_reg[i] <= h_reg[i+1];
            h_reg[7] <= h_reg[0];
        end
    end

    assign stat.fill  = fill_reg;
    assign stat.rnd   = rnd_reg;
    assign chain_head = h_reg[0];

endmodule

[design/sha256_ctrl.sv]
// Controller: sequences byte intake, padding, compression and digest output.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  sha_in_t   in_data,
    output logic      in_stall,
    input  logic      out_stall,
    output logic      out_valid,
    output logic [2:0] out_index,
    output sha_cmd_t  cmd,
    input  sha_stat_t stat
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_ROUND = 7'b0000100,
        S_FOLD  = 7'b0001000,
        S_PAD   = 7'b0010000,
        S_LEN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;      // message end pending
    logic       padded_reg, padded_next; // pad mark already written
    logic [2:0] idx_reg, idx_next;
    logic       take;

    assign in_stall  = (state_reg != S_IDLE);
    assign take      = in_valid && (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        padded_next = padded_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.in_byte = in_data.data_byte;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    fin_next    = in_data.last_byte;
                    padded_next = 1'b0;
                    if (in_data.has_byte)
                    begin
                        cmd.write_byte = 1'b1;
                        cmd.count_byte = 1'b1;
                        if (stat.fill == 6'd63)
                            state_next = S_START;
                        else if (in_data.last_byte)
                            state_next = S_PAD;
                    end
                    else if (in_data.last_byte)
                        state_next = S_PAD;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.rnd == 6'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (padded_reg && idx_reg == 3'd1)
                    state_next = S_OUT;
                else
                    state_next = S_PAD;
                idx_next = '0;
            end
            S_PAD:
            begin
                // Write pad mark, then zeros up to the length field or block end.
                cmd.write_byte = 1'b1;
                cmd.in_byte    = padded_reg ? 8'h00 : PadMark;
                padded_next    = 1'b1;
                if (stat.fill == 6'd63)
                    state_next = S_START;
                else if (stat.fill == LenPos - 6'd1)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.load_len = 1'b1;
                cmd.reinit   = 1'b0;
                idx_next     = 3'd1; // marks the final block
                state_next   = S_START;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.shift_out = 1'b0;
                        cmd.reinit    = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            padded_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            padded_reg <= padded_next;
            idx_reg    <= idx_next;
        end
    end

    // Rounds only run inside a compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> (state_reg == S_ROUND))
        else $error("round outside compression");
    // Fold follows the last round.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && stat.rnd == 6'd63) |=> (state_reg == S_FOLD))
        else $error("fold did not follow round 63");
    // Digest output starts at word zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (idx_reg == 3'd0))
        else $error("digest did not start at h0");

endmodule

[design/sha256_stream_hasher_unit.sv]
// Top level: SHA-256 stream hasher, byte requests in, digest word requests out.
//
// Input channel: one request per message byte (data_byte, has_byte, last_byte).
// A request with last_byte set closes the message; has_byte clear with last_byte
// set hashes what was sent so far (the empty message at a message start).
// Output channel: eight requests per message, h0 first, word_index 0..7,
// last_word set on the eighth.
// Intake: a byte that neither fills a block nor ends the message leaves the
// unit ready for the next. The 64th byte of a block starts a compression: a
// load step, 64 rounds on one shared round unit, then a fold step. Finishing
// pads one byte per cycle up to the length field, then compresses (one or two
// blocks) and presents the digest from the chain registers, one word per cycle
// while out_stall is low.
// in_stall is high whenever a block or digest is in progress. A stall on the
// output holds the current word; nothing is lost.
// Reset loads the initial hash values and clears the byte and fill counts.
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output sha_out_t out_data
);
    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] chain_head;
    logic [2:0]  out_index;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_index (out_index),
        .cmd       (cmd),
        .stat      (stat)
    );

    sha256_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .chain_head (chain_head)
    );

    // Chain rotates one word per accepted request, so word 0 is always h[index].
    assign out_data.digest_word = chain_head;
    assign out_data.word_index  = out_index;
    assign out_data.last_word   = (out_index == 3'd7);

endmodule

[bench/sha256_stream_hasher_unit_tb.sv]
// Testbench for the SHA-256 stream hasher: random byte messages checked against a digest predictor.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;
    import sha256_pkg::*;

    // Digest predictor plus the queue of digest words still owed by the block.
    class digest_board;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [60:0] msg_len;
        sha_out_t    owed [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            fill = 0;
            msg_len = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void crunch();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] t1, t2, wv, a15, a2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            v = chain;
            for (int r = 0; r < 64; r++)
            begin
                if (r < 16)
                    wv = w[r];
                else
                begin
                    a15 = w[(r - 15) & 15];
                    a2 = w[(r - 2) & 15];
                    wv = w[r & 15] + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3))
                       + w[(r - 7) & 15] + (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10));
                    w[r & 15] = wv;
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wv;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        // Note one accepted request and queue the digest it completes, if any.
        function void note_request(sha_in_t req);
            logic [63:0] bits;
            sha_out_t o;
            if (req.has_byte)
            begin
                blk[fill] = req.data_byte;
                fill++;
                msg_len++;
                if (fill == 64)
                begin
                    crunch();
                    fill = 0;
                end
            end
            if (!req.last_byte)
                return;
            bits = {msg_len, 3'b000};
            blk[fill] = PadMark;
            fill++;
            if (fill > 56)
            begin
                while (fill < 64)
                    blk[fill++] = 8'h00;
                crunch();
                fill = 0;
            end
            while (fill < 56)
                blk[fill++] = 8'h00;
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bits[63 - 8*i -: 8];
            crunch();
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = chain[i];
                o.word_index = i[2:0];
                o.last_word = (i == 7);
                owed = {owed, o};
            end
            restart();
        endfunction

        function void check_word(sha_out_t got);
            sha_out_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected digest word %h", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word expected %0d actual %0d", want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    sha_out_t out_data;

    digest_board board;
    int          burst_left;
    bit          hold_out;     // long receiver hold-off requested
    bit          drive_done;

    sha256_stream_hasher_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Send one request; hold it until accepted. Bursts with random gaps between them.
    task automatic send_request(input logic [7:0] b, input logic hb, input logic lb);
        sha_in_t req;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.data_byte = b;
        req.has_byte = hb;
        req.last_byte = lb;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(req);
    endtask

    // One message of n bytes with random content, then a finish.
    // Closing either on the last byte itself or with a separate empty finish.
    task automatic send_message(input int n, input int fill_mode);
        logic [7:0] b;
        bit joint_last;
        joint_last = (n > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            case (fill_mode)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'hff;
                default: b = 8'h00;
            endcase
            send_request(b, 1'b1, joint_last && (i == n - 1));
            // noise: an idle request without a byte that does nothing
            if ($urandom_range(0, 30) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        if (!joint_last)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Pause the sender until every owed digest word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall pattern, plus a long counted hold-off on request.
    initial
    begin
        int hold_cnt;
        out_stall = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_out && hold_cnt == 0)
                hold_cnt = 600;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                if (hold_cnt == 0)
                    hold_out = 1'b0;
                out_stall <= 1'b1;
            end
            else if ((($urandom_range(0, 255)) & 8'hc0) == 0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: check each accepted digest word.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(out_data);
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int sent;
        int n;
        board = new();
        hold_out = 1'b0;
        drive_done = 1'b0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single bytes of each extreme, and the message abc.
        send_message(0, 0);
        send_request(8'h00, 1'b0, 1'b0);
        send_message(1, 1);
        send_message(1, 2);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        drain();

        // Hold the output off while several messages are sent behind the first.
        hold_out = 1'b1;
        send_message(2, 0);
        send_message(0, 0);
        send_message(3, 0);
        drain();

        // Random: mostly short messages, a few across the pad and block borders.
        sent = 0;
        while (sent < 370)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(55, 57);
                1: n = $urandom_range(63, 65);
                2: n = $urandom_range(100, 130);
                3: n = 0;
                default: n = $urandom_range(1, 20);
            endcase
            send_message(n, ($urandom_range(0, 7) == 0) ? 1 : 0);
            sent += n + 1;
            if ($urandom_range(0, 5) == 0)
                drain();
        end
        in_valid <= 1'b0;
        drive_done = 1'b1;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
